FILE: src/vfa_pkg.sv
// Shared types, constants and register codes of the vitals and fall alert block.
package vfa_pkg;

    // Per-patient detector storage depth
    localparam int NUM_PATIENTS = 2;

    // Classification queue between front and back
    localparam int Q_AW    = 1;
    localparam int Q_DEPTH = 1 << Q_AW;

    // Fixed detector thresholds (accel 1/1024 g, gyro 1/16 dps)
    localparam logic [31:0] FREEFALL_SQ = 32'd262144;   // (0.5 g)^2
    localparam logic [31:0] IMPACT_SQ   = 32'd6553600;  // (2.5 g)^2
    localparam logic [15:0] LEVEL_LIMIT = 16'd512;      // 0.5 g
    localparam logic [16:0] STILL_LIMIT = 17'd160;      // 10 dps

    // Configuration register indexes
    localparam logic [2:0] REG_HR_LOW     = 3'd0;
    localparam logic [2:0] REG_HR_HIGH    = 3'd1;
    localparam logic [2:0] REG_TEMP_HIGH  = 3'd2;
    localparam logic [2:0] REG_TEMP_LOW   = 3'd3;
    localparam logic [2:0] REG_SPO2_LOW   = 3'd4;
    localparam logic [2:0] REG_FF_TIMEOUT = 3'd5;
    localparam logic [2:0] REG_STILL_HOLD = 3'd6;
    localparam logic [2:0] REG_GYRO_THR   = 3'd7;

    // Alert flag bit positions
    localparam int FLAG_HR_LOW    = 0;
    localparam int FLAG_HR_HIGH   = 1;
    localparam int FLAG_TEMP_HIGH = 2;
    localparam int FLAG_TEMP_LOW  = 3;
    localparam int FLAG_SPO2_LOW  = 4;
    localparam int FLAG_FALL      = 5;

    typedef enum logic [3:0] {
        ST_NORMAL   = 4'b0001,
        ST_FREEFALL = 4'b0010,
        ST_IMPACT   = 4'b0100,
        ST_FLAT     = 4'b1000
    } t_stage;

    typedef struct packed {
        logic [0:0]          patient_index;
        logic [31:0]         now_ms;
        logic [8:0]          heart_rate;
        logic [9:0]          spo2_tenths;
        logic signed [11:0]  temp_decideg;
        logic signed [15:0]  accel_x;
        logic signed [15:0]  accel_y;
        logic signed [15:0]  accel_z;
        logic signed [15:0]  rate_x;
        logic signed [15:0]  rate_y;
        logic signed [15:0]  rate_z;
    } t_in_item;

    typedef struct packed {
        logic [0:0]          out_patient;
        logic [8:0]          out_heart_rate;
        logic [9:0]          out_spo2;
        logic signed [11:0]  out_temp;
        logic [5:0]          alert_flags;
    } t_out_item;

    typedef struct packed {
        logic [8:0]          hr_low;
        logic [8:0]          hr_high;
        logic signed [11:0]  temp_high;
        logic signed [11:0]  temp_low;
        logic [9:0]          spo2_low;
        logic [15:0]         ff_timeout;
        logic [15:0]         still_hold;
        logic [16:0]         gyro_thr;
    } t_cfg;

    // Classified sample handed from front to back
    typedef struct packed {
        logic [0:0]          patient;
        logic [31:0]         now_ms;
        logic [8:0]          heart_rate;
        logic [9:0]          spo2;
        logic signed [11:0]  temp;
        logic [4:0]          vital_flags;
        logic                acc_low;
        logic                acc_high;
        logic                level;
        logic                gyro_over;
        logic                still;
    } t_cls;

endpackage

FILE: src/vfa_front.sv
// Front end: accept samples, square and compare, produce classified items.
module vfa_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  vfa_pkg::t_in_item   i_in_item,
    input  vfa_pkg::t_cfg       i_cfg,
    input  logic                i_q_full,
    output logic                o_cls_valid,
    output vfa_pkg::t_cls       o_cls
);
    import vfa_pkg::*;

    typedef struct packed {
        logic [0:0]          patient;
        logic [31:0]         now_ms;
        logic [8:0]          heart_rate;
        logic [9:0]          spo2;
        logic signed [11:0]  temp;
        logic [4:0]          vital_flags;
        logic [30:0]         sq_x;
        logic [30:0]         sq_y;
        logic [30:0]         sq_z;
        logic [15:0]         az_abs;
        logic [16:0]         gyro_sum;
    } t_s1;

    logic               r_s1_valid, n_s1_valid;
    t_s1                r_s1, n_s1;
    logic signed [31:0] w_px, w_py, w_pz;
    logic [15:0]        w_rx_abs, w_ry_abs, w_rz_abs, w_az_abs;
    logic [4:0]         w_vflags;
    logic [31:0]        w_acc;
    logic               w_accept, w_move;

    function automatic logic [15:0] abs16(input logic signed [15:0] v);
        return v[15] ? 16'(~v + 16'sd1) : 16'(v);
    endfunction

    assign w_move     = r_s1_valid && !i_q_full;
    assign o_in_ready = !r_s1_valid || !i_q_full;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_px = $signed(i_in_item.accel_x) * $signed(i_in_item.accel_x);
    assign w_py = $signed(i_in_item.accel_y) * $signed(i_in_item.accel_y);
    assign w_pz = $signed(i_in_item.accel_z) * $signed(i_in_item.accel_z);

    assign w_rx_abs = abs16(i_in_item.rate_x);
    assign w_ry_abs = abs16(i_in_item.rate_y);
    assign w_rz_abs = abs16(i_in_item.rate_z);
    assign w_az_abs = abs16(i_in_item.accel_z);

    always_comb begin
        w_vflags = '0;
        w_vflags[FLAG_HR_LOW]    = i_in_item.heart_rate < i_cfg.hr_low;
        w_vflags[FLAG_HR_HIGH]   = i_in_item.heart_rate > i_cfg.hr_high;
        w_vflags[FLAG_TEMP_HIGH] = $signed(i_in_item.temp_decideg) > $signed(i_cfg.temp_high);
        w_vflags[FLAG_TEMP_LOW]  = $signed(i_in_item.temp_decideg) < $signed(i_cfg.temp_low);
        w_vflags[FLAG_SPO2_LOW]  = i_in_item.spo2_tenths < i_cfg.spo2_low;
    end

    always_comb begin
        n_s1             = r_s1;
        n_s1_valid       = w_accept ? 1'b1 : (w_move ? 1'b0 : r_s1_valid);
        if (w_accept) begin
            n_s1.patient     = i_in_item.patient_index;
            n_s1.now_ms      = i_in_item.now_ms;
            n_s1.heart_rate  = i_in_item.heart_rate;
            n_s1.spo2        = i_in_item.spo2_tenths;
            n_s1.temp        = i_in_item.temp_decideg;
            n_s1.vital_flags = w_vflags;
            n_s1.sq_x        = w_px[30:0];
            n_s1.sq_y        = w_py[30:0];
            n_s1.sq_z        = w_pz[30:0];
            n_s1.az_abs      = w_az_abs;
            n_s1.gyro_sum    = 17'(w_rx_abs) + 17'(w_ry_abs) + 17'(w_rz_abs);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
        r_s1 <= n_s1;
    end

    // Magnitude sum and classification on the registered squares
    assign w_acc = 32'(r_s1.sq_x) + 32'(r_s1.sq_y) + 32'(r_s1.sq_z);

    assign o_cls_valid       = r_s1_valid;
    assign o_cls.patient     = r_s1.patient;
    assign o_cls.now_ms      = r_s1.now_ms;
    assign o_cls.heart_rate  = r_s1.heart_rate;
    assign o_cls.spo2        = r_s1.spo2;
    assign o_cls.temp        = r_s1.temp;
    assign o_cls.vital_flags = r_s1.vital_flags;
    assign o_cls.acc_low     = w_acc < FREEFALL_SQ;
    assign o_cls.acc_high    = w_acc > IMPACT_SQ;
    assign o_cls.level       = r_s1.az_abs < LEVEL_LIMIT;
    assign o_cls.gyro_over   = r_s1.gyro_sum > i_cfg.gyro_thr;
    assign o_cls.still       = r_s1.gyro_sum < STILL_LIMIT;

endmodule

FILE: src/vfa_queue.sv
// Short FIFO of classified items between front and back.
module vfa_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  vfa_pkg::t_cls   i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output vfa_pkg::t_cls   o_data
);
    import vfa_pkg::*;

    t_cls               r_mem [Q_DEPTH];
    logic [Q_AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [Q_AW:0]      r_count;
    logic               w_push, w_pop;

    assign o_full  = r_count == (Q_AW+1)'(Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: src/vfa_back.sv
// Back end: per-patient fall detector update and registered result stage.
module vfa_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_head_valid,
    input  vfa_pkg::t_cls       i_head,
    output logic                o_pop,
    input  vfa_pkg::t_cfg       i_cfg,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output vfa_pkg::t_out_item  o_out_item
);
    import vfa_pkg::*;

    t_stage         r_stage [NUM_PATIENTS];
    logic [31:0]    r_start [NUM_PATIENTS];
    logic           r_out_valid;
    t_out_item      r_out;

    t_stage         w_cur, w_nxt;
    logic [31:0]    w_elapsed;
    logic           w_set_start, w_fall, w_pat_ok;

    assign o_pop     = i_head_valid && (!r_out_valid || i_out_ready);
    assign w_pat_ok  = 32'(i_head.patient) < 32'(NUM_PATIENTS);
    assign w_cur     = r_stage[i_head.patient];
    assign w_elapsed = i_head.now_ms - r_start[i_head.patient];

    always_comb begin
        w_nxt       = w_cur;
        w_set_start = 1'b0;
        w_fall      = 1'b0;
        case (w_cur)
            ST_NORMAL: begin
                if (i_head.acc_low) begin
                    w_nxt       = ST_FREEFALL;
                    w_set_start = 1'b1;
                end
            end
            ST_FREEFALL: begin
                if (i_head.acc_high) begin
                    w_nxt = ST_IMPACT;
                end else if (w_elapsed > 32'(i_cfg.ff_timeout)) begin
                    w_nxt = ST_NORMAL;
                end
            end
            ST_IMPACT: begin
                if (i_head.level && i_head.gyro_over) begin
                    w_nxt       = ST_FLAT;
                    w_set_start = 1'b1;
                end else begin
                    w_nxt = ST_NORMAL;
                end
            end
            ST_FLAT: begin
                if (!i_head.still) begin
                    w_nxt = ST_NORMAL;
                end else if (w_elapsed > 32'(i_cfg.still_hold)) begin
                    w_nxt  = ST_NORMAL;
                    w_fall = 1'b1;
                end
            end
            default: begin
                w_nxt = ST_NORMAL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_PATIENTS; i++) begin
                r_stage[i] <= ST_NORMAL;
                r_start[i] <= '0;
            end
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop && w_pat_ok) begin
                r_stage[i_head.patient] <= w_nxt;
                if (w_set_start) begin
                    r_start[i_head.patient] <= i_head.now_ms;
                end
            end
        end
        if (o_pop) begin
            r_out.out_patient    <= i_head.patient;
            r_out.out_heart_rate <= i_head.heart_rate;
            r_out.out_spo2       <= i_head.spo2;
            r_out.out_temp       <= i_head.temp;
            r_out.alert_flags    <= {w_fall && w_pat_ok, i_head.vital_flags};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

FILE: src/vitals_and_fall_alert.sv
// Top level of the vitals and fall alert block: config registers and pipeline.
//
// Usage
//   Input channel (i_in_valid / o_in_ready / i_in_item) carries one sensor
//   sample: patient, arrival tick, vitals, three accel and three gyro axes.
//   Output channel (o_out_valid / i_out_ready / o_out_item) returns one item
//   per sample, in order: the echoed vitals plus six alert flags. The fall
//   flag is set only on the sample that completes a fall sequence.
//   Path: an accepted sample is registered in the front stage, pushed into
//   the queue, then registered in the back result stage. Throughput: one
//   sample per cycle when not stalled, set by the per-patient detector update.
//   Configuration: i_cfg_we writes i_cfg_data (masked to the register's
//   width) into register i_cfg_idx at the clock edge; write only while idle.
//   Reset (i_rst_n low, synchronous) restores default thresholds, returns
//   every patient's detector to the normal stage with a zero start tick, and
//   empties the pipeline.
//   Stall: when i_out_ready is low the result holds; the front keeps taking
//   samples until its stage and the two-entry queue fill, then drops
//   o_in_ready.
module vitals_and_fall_alert (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  vfa_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output vfa_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [16:0]         i_cfg_data
);
    import vfa_pkg::*;

    t_cfg   r_cfg;
    t_cls   w_front_cls, w_head;
    logic   w_front_valid, w_q_full, w_head_valid, w_pop;

    // Configuration registers: take the low bits that fit each register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hr_low     <= 9'd60;
            r_cfg.hr_high    <= 9'd100;
            r_cfg.temp_high  <= 12'sd380;
            r_cfg.temp_low   <= 12'sd350;
            r_cfg.spo2_low   <= 10'd900;
            r_cfg.ff_timeout <= 16'd1000;
            r_cfg.still_hold <= 16'd1500;
            r_cfg.gyro_thr   <= 17'd2400;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_HR_LOW:     r_cfg.hr_low     <= i_cfg_data[8:0];
                REG_HR_HIGH:    r_cfg.hr_high    <= i_cfg_data[8:0];
                REG_TEMP_HIGH:  r_cfg.temp_high  <= i_cfg_data[11:0];
                REG_TEMP_LOW:   r_cfg.temp_low   <= i_cfg_data[11:0];
                REG_SPO2_LOW:   r_cfg.spo2_low   <= i_cfg_data[9:0];
                REG_FF_TIMEOUT: r_cfg.ff_timeout <= i_cfg_data[15:0];
                REG_STILL_HOLD: r_cfg.still_hold <= i_cfg_data[15:0];
                REG_GYRO_THR:   r_cfg.gyro_thr   <= i_cfg_data[16:0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    // Front: accept, square, compare, classify
    vfa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .i_cfg       (r_cfg),
        .i_q_full    (w_q_full),
        .o_cls_valid (w_front_valid),
        .o_cls       (w_front_cls)
    );

    // Decouple front and back so each can stall on its own
    vfa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .i_data  (w_front_cls),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_data  (w_head)
    );

    // Back: advance the patient's detector and register the result
    vfa_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .i_cfg        (r_cfg),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_item   (o_out_item)
    );

endmodule

FILE: src/vfa_checker.sv
// Port-level checker for the vitals and fall alert block, with its bind.
module vfa_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_in_ready,
    input  logic                o_out_valid,
    input  logic                i_out_ready,
    input  vfa_pkg::t_out_item  o_out_item
);
    import vfa_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_item))
        else $error("result changed while stalled");

    // Pipeline is empty right after reset, so the input side is open
    a_ready_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> o_in_ready)
        else $error("input not ready after reset");

    // A fall returns the detector to normal: the next item of the same
    // patient cannot report another fall
    a_no_double_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_item.alert_flags[FLAG_FALL]) ##1
        (o_out_valid && o_out_item.out_patient == $past(o_out_item.out_patient))
        |-> !o_out_item.alert_flags[FLAG_FALL])
        else $error("fall reported twice in a row");

endmodule

bind vitals_and_fall_alert vfa_checker u_vfa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
